// ===== design/watermark_allocator_with_table_core_assert.svh =====
// Assertion macros shared by the allocator RTL.
// Included by files that check properties; no other dependencies.
`ifndef WATERMARK_ALLOCATOR_WITH_TABLE_CORE_ASSERT_SVH
`define WATERMARK_ALLOCATOR_WITH_TABLE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define WAT_ASSERT_CR(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("allocator assertion failed");
`define WAT_ASSERT(lbl, prop) `WAT_ASSERT_CR(lbl, clk, rst, prop)
`else
`define WAT_ASSERT_CR(lbl, ck, rs, prop)
`define WAT_ASSERT(lbl, prop)
`endif

`endif

// ===== design/wat_pkg.sv =====
// Package for the watermark allocator: item types, codes and scan control types.
// No dependencies.
package wat_pkg;

  localparam int SIZE_W = 18;
  localparam logic [SIZE_W-1:0] ROUND_ADD  = 18'd15;
  localparam logic [SIZE_W-1:0] ROUND_MASK = 18'h3FFF0;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SLOT   = 2'd1;
  localparam logic [1:0] ST_POOL_FULL = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [16:0] alloc_size;
    logic [15:0] free_offset;
  } req_t;

  typedef struct packed {
    logic [15:0] chunk_offset;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic free_mode;
  } scan_cmd_t;

  typedef struct packed {
    logic done;
    logic found;
  } scan_stat_t;

endpackage

// ===== design/wat_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module wat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/wat_slot_scan.sv =====
// Slot table walker: reads every table entry once through the RAM read port and
// finds the first free slot (allocate) or the first live match plus the highest
// remaining end (free). Depends on wat_pkg.
module wat_slot_scan #(
  parameter int SLOTS  = 64,
  parameter int MARK_W = 17
) (
  input  logic                       clk,
  input  logic                       rst,
  input  wat_pkg::scan_cmd_t         cmd,
  input  logic [15:0]                offset,
  input  logic [SLOTS-1:0]           live,
  input  logic [2*MARK_W-1:0]        rd_data,
  output logic [$clog2(SLOTS)-1:0]   rd_addr,
  output wat_pkg::scan_stat_t        stat,
  output logic [$clog2(SLOTS)-1:0]   idx,
  output logic [MARK_W-1:0]          max_end
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = (MARK_W > 16) ? MARK_W : 16;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic             dvalid;
  logic [IDX_W-1:0] didx;
  logic             free_mode;
  logic [15:0]      off_r;
  logic             found;
  logic             done;

  logic              live_d;
  logic [MARK_W-1:0] start_d;
  logic [MARK_W-1:0] end_d;
  logic              hit;

  assign rd_addr = cnt[IDX_W-1:0];
  assign live_d  = live[didx];
  assign start_d = rd_data[2*MARK_W-1:MARK_W];
  assign end_d   = rd_data[MARK_W-1:0];
  assign hit     = live_d && (CMP_W'(start_d) == CMP_W'(off_r));

  assign stat.done  = done;
  assign stat.found = found;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      dvalid <= 1'b0;
      done   <= 1'b0;
      found  <= 1'b0;
      cnt    <= '0;
    end else begin
      dvalid <= busy;
      didx   <= cnt[IDX_W-1:0];
      done   <= dvalid && (didx == LAST);
      if (cmd.start) begin
        busy      <= 1'b1;
        cnt       <= '0;
        found     <= 1'b0;
        max_end   <= '0;
        free_mode <= cmd.free_mode;
        off_r     <= offset;
      end else begin
        if (busy) begin
          cnt <= cnt + CNT_W'(1);
          if (cnt[IDX_W-1:0] == LAST) begin
            busy <= 1'b0;
          end
        end
        if (dvalid) begin
          if (free_mode) begin
            // The first live match is the slot to clear; all other live
            // slots count toward the new top mark.
            if (hit && !found) begin
              found <= 1'b1;
              idx   <= didx;
            end else if (live_d && (end_d > max_end)) begin
              max_end <= end_d;
            end
          end else if (!live_d && !found) begin
            found <= 1'b1;
            idx   <= didx;
          end
        end
      end
    end
  end

endmodule

// ===== design/watermark_allocator_with_table_core.sv =====
// Top level of the watermark allocator with a slot table.
// Depends on wat_pkg, wat_ram, wat_slot_scan and the assertion macro header.
//
//   Channel  Signals                    Carries
//   request  req_valid, req_ready, req  wat_pkg::req_t (cmd, alloc_size, free_offset)
//   result   rsp_valid, rsp_ready, rsp  wat_pkg::rsp_t (chunk_offset, status)
//
// An allocate or free walks the whole slot table before its result: the
// slot walker reads one table entry per cycle through the single RAM read port.
// A zero-size allocate skips the walk. One item is in flight at a time.
// Reset is synchronous; all slots are free and the top mark is zero right
// after reset, with no clearing pass. A stalled result holds the block in its
// final step; the next item is accepted once the block returns to idle.
module watermark_allocator_with_table_core #(
  parameter int SLOTS      = 64,
  parameter int POOL_BYTES = 65536
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  wat_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output wat_pkg::rsp_t rsp
);

  `include "watermark_allocator_with_table_core_assert.svh"

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int MARK_W = $clog2(POOL_BYTES + 1);
  localparam int SIZE_W = wat_pkg::SIZE_W;
  localparam int SUM_W  = ((MARK_W > SIZE_W) ? MARK_W : SIZE_W) + 1;
  localparam int ENT_W  = 2 * MARK_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;

  // Item held for the duration of its scan.
  logic              is_free;
  logic              zero_req;
  logic [SIZE_W-1:0] size;

  // Allocator state: live bits in flops, start and end of each slot in RAM.
  logic [SLOTS-1:0]  live;
  logic [MARK_W-1:0] top_mark;

  logic                accept;
  logic                is_alloc_in;
  logic                zero_in;
  logic [SIZE_W-1:0]   size_in;
  logic                out_free;
  logic                finish;
  logic [SUM_W-1:0]    sum;
  logic                over;
  logic                alloc_ok;
  logic                free_ok;
  wat_pkg::rsp_t       res;

  wat_pkg::scan_cmd_t  scan_cmd;
  wat_pkg::scan_stat_t scan_stat;
  logic [IDX_W-1:0]    scan_idx;
  logic [MARK_W-1:0]   scan_max_end;
  logic [IDX_W-1:0]    rd_addr;
  logic [ENT_W-1:0]    rd_data;
  logic [ENT_W-1:0]    wr_data;

  assign req_ready   = (state == S_IDLE);
  assign accept      = req_valid && req_ready;
  assign is_alloc_in = (req.cmd == wat_pkg::CMD_ALLOC);
  assign zero_in     = (req.alloc_size == '0);
  assign size_in     = (SIZE_W'(req.alloc_size) + wat_pkg::ROUND_ADD) & wat_pkg::ROUND_MASK;

  // A zero-size allocate skips the table walk entirely.
  assign scan_cmd.start     = accept && !(is_alloc_in && zero_in);
  assign scan_cmd.free_mode = (req.cmd == wat_pkg::CMD_FREE);

  assign out_free = !rsp_valid || rsp_ready;
  assign finish   = (state == S_FINISH) && out_free;

  // Pool check: the new chunk must end within the pool.
  assign sum  = SUM_W'(top_mark) + SUM_W'(size);
  assign over = sum > SUM_W'(POOL_BYTES);

  assign alloc_ok = finish && !is_free && !zero_req && scan_stat.found && !over;
  assign free_ok  = finish && is_free && scan_stat.found;

  // The slot entry holds the chunk start and its end (start plus length).
  assign wr_data = {top_mark, MARK_W'(sum)};

  always_comb begin
    res.chunk_offset = '0;
    res.status       = wat_pkg::ST_OK;
    if (is_free) begin
      if (!scan_stat.found) begin
        res.status = wat_pkg::ST_NOT_FOUND;
      end
    end else if (zero_req) begin
      res.chunk_offset = 16'(top_mark);
    end else if (!scan_stat.found) begin
      res.status = wat_pkg::ST_NO_SLOT;
    end else if (over) begin
      res.status = wat_pkg::ST_POOL_FULL;
    end else begin
      res.chunk_offset = 16'(top_mark);
    end
  end

  wat_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (alloc_ok),
    .waddr (scan_idx),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  wat_slot_scan #(
    .SLOTS  (SLOTS),
    .MARK_W (MARK_W)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .cmd     (scan_cmd),
    .offset  (req.free_offset),
    .live    (live),
    .rd_data (rd_data),
    .rd_addr (rd_addr),
    .stat    (scan_stat),
    .idx     (scan_idx),
    .max_end (scan_max_end)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      live      <= '0;
      top_mark  <= '0;
    end else begin
      // A new result may replace one that leaves in the same cycle.
      if (finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            is_free  <= (req.cmd == wat_pkg::CMD_FREE);
            zero_req <= is_alloc_in && zero_in;
            size     <= size_in;
            state    <= (is_alloc_in && zero_in) ? S_FINISH : S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_stat.done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            rsp <= res;
            if (alloc_ok) begin
              live[scan_idx] <= 1'b1;
              top_mark       <= MARK_W'(sum);
            end
            if (free_ok) begin
              // The walker has already left the freed slot out of the maximum.
              live[scan_idx] <= 1'b0;
              top_mark       <= scan_max_end;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // With no live slot the top mark must have fallen back to zero.
  `WAT_ASSERT(a_empty_mark_zero, (live == '0) |-> (top_mark == '0))
  // The mark never passes the end of the pool.
  `WAT_ASSERT(a_mark_in_pool, top_mark <= MARK_W'(POOL_BYTES))
  // A new result appears only out of the final step.
  `WAT_ASSERT(a_rsp_from_finish, $rose(rsp_valid) |-> $past(state == S_FINISH))
  // A successful free releases exactly one slot.
  `WAT_ASSERT(a_free_drops_one, free_ok |=> ($countones(live) + 1 == $past($countones(live))))

endmodule

// ===== bench/watermark_allocator_with_table_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for watermark_allocator_with_table_core.
// Drives allocate/free items and checks every result against the directed rows or a slot-table model.
// Depends on wat_pkg and the allocator RTL.
module watermark_allocator_with_table_core_tb;

  localparam int SLOTS          = 64;
  localparam int POOL_BYTES     = 65536;
  localparam int RAND_ITEMS     = 950;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_MAX     = 10;
  localparam int TAIL_CYCLES    = SLOTS + 8;

  logic          clk;
  logic          rst;
  logic          req_valid;
  logic          req_ready;
  wat_pkg::req_t req;
  logic          rsp_valid;
  logic          rsp_ready;
  wat_pkg::rsp_t rsp;

  watermark_allocator_with_table_core #(
    .SLOTS     (SLOTS),
    .POOL_BYTES(POOL_BYTES)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  // One row of the directed part. Where "known" is set, the expected result is
  // taken from the row itself; otherwise the slot-table model supplies it.
  typedef struct packed {
    logic        cmd;
    logic [16:0] size;
    logic [15:0] offset;
    logic        known;
    logic [15:0] want_offset;
    logic [1:0]  want_status;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // A zero-size allocate right after reset returns the mark, which is zero.
    '{wat_pkg::CMD_ALLOC, 17'd0,      16'h1234, 1'b1, 16'd0,  wat_pkg::ST_OK},
    // Free slots never match, not even at offset zero.
    '{wat_pkg::CMD_FREE,  17'd0,      16'd0,    1'b1, 16'd0,  wat_pkg::ST_NOT_FOUND},
    // The largest request that fits fills the whole pool.
    '{wat_pkg::CMD_ALLOC, 17'd65536,  16'd0,    1'b1, 16'd0,  wat_pkg::ST_OK},
    // Zero-size allocate at a full pool: the mark 65536 reads as zero.
    '{wat_pkg::CMD_ALLOC, 17'd0,      16'd0,    1'b1, 16'd0,  wat_pkg::ST_OK},
    '{wat_pkg::CMD_ALLOC, 17'd1,      16'd0,    1'b1, 16'd0,  wat_pkg::ST_POOL_FULL},
    '{wat_pkg::CMD_ALLOC, 17'h1FFFF,  16'hFFFF, 1'b1, 16'd0,  wat_pkg::ST_POOL_FULL},
    '{wat_pkg::CMD_FREE,  17'h1FFFF,  16'hFFFF, 1'b1, 16'd0,  wat_pkg::ST_NOT_FOUND},
    '{wat_pkg::CMD_FREE,  17'd0,      16'd0,    1'b1, 16'd0,  wat_pkg::ST_OK},
    // Rounding of the largest request goes to 131072, never wraps to zero.
    '{wat_pkg::CMD_ALLOC, 17'h1FFFF,  16'd0,    1'b1, 16'd0,  wat_pkg::ST_POOL_FULL},
    '{wat_pkg::CMD_ALLOC, 17'd1,      16'd0,    1'b1, 16'd0,  wat_pkg::ST_OK},
    '{wat_pkg::CMD_ALLOC, 17'd16,     16'd0,    1'b1, 16'd16, wat_pkg::ST_OK},
    '{wat_pkg::CMD_ALLOC, 17'd17,     16'd0,    1'b1, 16'd32, wat_pkg::ST_OK},
    // Exact fit of the remaining room.
    '{wat_pkg::CMD_ALLOC, 17'd65472,  16'd0,    1'b1, 16'd64, wat_pkg::ST_OK},
    '{wat_pkg::CMD_ALLOC, 17'd1,      16'd0,    1'b1, 16'd0,  wat_pkg::ST_POOL_FULL},
    // Freeing a middle chunk leaves the mark where it is.
    '{wat_pkg::CMD_FREE,  17'd0,      16'd16,   1'b1, 16'd0,  wat_pkg::ST_OK},
    '{wat_pkg::CMD_FREE,  17'd0,      16'd16,   1'b1, 16'd0,  wat_pkg::ST_NOT_FOUND},
    // Freeing the top chunk drops the mark to the highest live end.
    '{wat_pkg::CMD_FREE,  17'd0,      16'd64,   1'b1, 16'd0,  wat_pkg::ST_OK},
    '{wat_pkg::CMD_ALLOC, 17'd0,      16'd0,    1'b1, 16'd64, wat_pkg::ST_OK},
    '{wat_pkg::CMD_ALLOC, 17'd15,     16'hA5A5, 1'b0, 16'd0,  wat_pkg::ST_OK},
    '{wat_pkg::CMD_ALLOC, 17'd65536,  16'd0,    1'b0, 16'd0,  wat_pkg::ST_OK},
    '{wat_pkg::CMD_FREE,  17'h15A5A,  16'd0,    1'b0, 16'd0,  wat_pkg::ST_OK},
    '{wat_pkg::CMD_ALLOC, 17'd65456,  16'd0,    1'b0, 16'd0,  wat_pkg::ST_OK},
    '{wat_pkg::CMD_ALLOC, 17'd0,      16'hFFFF, 1'b0, 16'd0,  wat_pkg::ST_OK},
    '{wat_pkg::CMD_FREE,  17'h1FFFF,  16'd80,   1'b0, 16'd0,  wat_pkg::ST_OK},
    '{wat_pkg::CMD_FREE,  17'd0,      16'd64,   1'b0, 16'd0,  wat_pkg::ST_OK}
  };

  // Model of the slot table and the top mark.
  bit          slot_used  [SLOTS];
  logic [16:0] slot_base  [SLOTS];
  logic [16:0] slot_bytes [SLOTS];
  logic [16:0] top_mark_q;

  // Results still owed by the block, oldest first.
  wat_pkg::rsp_t rsp_due [$];

  int   items_sent;
  int   results_seen;
  int   errors;
  int   cycles;
  int   status_seen [4];
  bit   calm;
  int   hold_asked;
  int   hold_served;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic wat_pkg::req_t make_req(logic cmd, logic [16:0] size,
                                             logic [15:0] offset);
    wat_pkg::req_t r;
    r.cmd         = cmd;
    r.alloc_size  = size;
    r.free_offset = offset;
    return r;
  endfunction

  function automatic int first_free_slot();
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_used[i]) return i;
    end
    return SLOTS;
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) n += slot_used[i];
    return n;
  endfunction

  // Returns a random live slot index; callers make sure one exists.
  function automatic int random_live_slot();
    int live [$];
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i]) live.push_back(i);
    end
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  // Apply one accepted item to the model and work out the result it causes.
  task automatic apply_request(input wat_pkg::req_t item, output wat_pkg::rsp_t result);
    int rounded;
    int slot;
    int hit;
    int mark;
    result.chunk_offset = 16'd0;
    result.status       = wat_pkg::ST_OK;
    if (item.cmd == wat_pkg::CMD_ALLOC) begin
      rounded = (int'(item.alloc_size) + 15) & ~32'd15;
      slot    = first_free_slot();
      if (rounded == 0) begin
        // Zero-size allocate: report the mark, take no slot, check nothing.
        result.chunk_offset = top_mark_q[15:0];
      end else if (slot >= SLOTS) begin
        // The slot check comes before the pool check.
        result.status = wat_pkg::ST_NO_SLOT;
      end else if (int'(top_mark_q) + rounded > POOL_BYTES) begin
        result.status = wat_pkg::ST_POOL_FULL;
      end else begin
        slot_used[slot]     = 1'b1;
        slot_base[slot]     = top_mark_q;
        slot_bytes[slot]    = 17'(rounded);
        result.chunk_offset = top_mark_q[15:0];
        top_mark_q          = 17'(int'(top_mark_q) + rounded);
      end
    end else begin
      hit = SLOTS;
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (slot_used[i] && slot_base[i] == {1'b0, item.free_offset}) hit = i;
      end
      if (hit >= SLOTS) begin
        result.status = wat_pkg::ST_NOT_FOUND;
      end else begin
        slot_used[hit] = 1'b0;
        mark = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_used[i] && int'(slot_base[i]) + int'(slot_bytes[i]) > mark) begin
            mark = int'(slot_base[i]) + int'(slot_bytes[i]);
          end
        end
        top_mark_q = 17'(mark);
      end
    end
  endtask

  // Offer one item, hold it until accepted, then record what it must produce.
  // Between items the request side may idle at random, except in the calm stretch.
  task automatic send_item(input wat_pkg::req_t item, input bit known,
                           input wat_pkg::rsp_t want);
    wat_pkg::rsp_t modeled;
    while (!calm && $urandom_range(0, 99) < 11) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    apply_request(item, modeled);
    rsp_due.push_back(known ? want : modeled);
    items_sent++;
  endtask

  // Request sizes: mostly small, some large, some that hit the pool boundary.
  function automatic logic [16:0] random_alloc_size();
    int pick;
    int room;
    pick = $urandom_range(0, 99);
    room = POOL_BYTES - int'(top_mark_q);
    if (pick < 45)      return 17'($urandom_range(1, 256));
    else if (pick < 65) return 17'($urandom_range(257, 4096));
    else if (pick < 72) return 17'($urandom_range(4097, 65536));
    else if (pick < 80) return 17'($urandom);
    else if (pick < 86) return 17'd0;
    else if (pick < 94) return 17'(room);
    else                return 17'(room + $urandom_range(1, 16));
  endfunction

  task automatic alloc_burst(input int n);
    repeat (n) begin
      send_item(make_req(wat_pkg::CMD_ALLOC, random_alloc_size(), 16'($urandom)),
                1'b0, '0);
    end
  endtask

  // Frees mostly hit a live chunk; the rest use a random offset or the top mark.
  task automatic free_burst(input int n);
    logic [15:0] offset;
    repeat (n) begin
      if (live_count() > 0 && $urandom_range(0, 99) < 80) begin
        offset = slot_base[random_live_slot()][15:0];
      end else if ($urandom_range(0, 1) == 0) begin
        offset = 16'($urandom);
      end else begin
        offset = top_mark_q[15:0];
      end
      send_item(make_req(wat_pkg::CMD_FREE, 17'($urandom), offset), 1'b0, '0);
    end
  endtask

  // Free every live chunk in random order, so the mark returns to zero.
  task automatic drain_table();
    while (live_count() > 0) begin
      send_item(make_req(wat_pkg::CMD_FREE, 17'($urandom),
                         slot_base[random_live_slot()][15:0]),
                1'b0, '0);
    end
  endtask

  // Take every slot with small chunks, then probe the no-free-slot case, alone
  // and together with a pool overflow, and release part of the table again.
  task automatic fill_table();
    if (top_mark_q > 17'd61000) drain_table();
    while (first_free_slot() < SLOTS) begin
      send_item(make_req(wat_pkg::CMD_ALLOC, 17'($urandom_range(1, 64)), 16'($urandom)),
                1'b0, '0);
    end
    send_item(make_req(wat_pkg::CMD_ALLOC, 17'd16, 16'($urandom)), 1'b0, '0);
    send_item(make_req(wat_pkg::CMD_ALLOC, 17'h1FFFF, 16'($urandom)), 1'b0, '0);
    send_item(make_req(wat_pkg::CMD_ALLOC, 17'd0, 16'($urandom)), 1'b0, '0);
    free_burst($urandom_range(1, 40));
  endtask

  // Compare one accepted result with the oldest expected one.
  task automatic score_result(input wat_pkg::rsp_t got);
    wat_pkg::rsp_t want;
    results_seen++;
    status_seen[got.status]++;
    if (rsp_due.size() == 0) begin
      errors++;
      if (errors <= REPORT_MAX) begin
        $display("result %0d arrived with nothing expected: chunk_offset %h status %0d",
                 results_seen, got.chunk_offset, got.status);
      end
    end else begin
      want = rsp_due.pop_front();
      if (got.chunk_offset !== want.chunk_offset || got.status !== want.status) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("result %0d mismatch: chunk_offset exp %h got %h, status exp %0d got %0d",
                   results_seen, want.chunk_offset, got.chunk_offset,
                   want.status, got.status);
        end
      end
    end
  endtask

  // Result side: accepts and checks items, idles at random, and serves the
  // long hold-off that the stimulus side asks for once.
  initial begin : rsp_side
    int hold_left;
    hold_left   = 0;
    hold_served = 0;
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) score_result(rsp);
      if (rst) begin
        rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left   = HOLD_CYCLES;
        rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 11) begin
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no item moves on either channel for too long.
  initial begin : watchdog
    int stuck;
    stuck  = 0;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
      if (stuck >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item accepted for %0d cycles, %0d results outstanding",
                 stuck, rsp_due.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Stimulus: reset, the directed table, then random traffic.
  initial begin : stimulus
    dir_row_t      row;
    wat_pkg::rsp_t want;
    int            pick;
    bit            hold_issued;
    rst        <= 1'b1;
    req_valid  <= 1'b0;
    req        <= '0;
    hold_asked <= 0;
    calm        = 1'b0;
    hold_issued = 1'b0;
    items_sent  = 0;
    results_seen = 0;
    errors      = 0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i]  = 1'b0;
      slot_base[i]  = '0;
      slot_bytes[i] = '0;
    end
    top_mark_q = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      row               = DIRECTED[i];
      want.chunk_offset = row.want_offset;
      want.status       = row.want_status;
      send_item(make_req(row.cmd, row.size, row.offset), row.known, want);
    end

    // Reach the full table early, then empty it, before the random mix.
    fill_table();
    drain_table();

    while (items_sent < DIR_ROWS + RAND_ITEMS) begin
      // A stretch of traffic with no idling on either side.
      calm = (items_sent >= DIR_ROWS + 300 && items_sent < DIR_ROWS + 480);
      // Once, stall the result side for a long time while items keep coming.
      if (!hold_issued && items_sent >= DIR_ROWS + 150) begin
        hold_asked <= hold_asked + 1;
        hold_issued = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 6)       fill_table();
      else if (pick < 12) drain_table();
      else if (pick < 55) alloc_burst($urandom_range(1, 6));
      else if (pick < 90) free_burst($urandom_range(1, 6));
      else begin
        repeat ($urandom_range(1, 3)) begin
          send_item(make_req(1'($urandom), 17'($urandom), 16'($urandom)), 1'b0, '0);
        end
      end
    end
    req_valid <= 1'b0;
    calm = 1'b0;

    while (rsp_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d items (%0d from the table) in %0d cycles; %0d results checked.",
             items_sent, DIR_ROWS, cycles, results_seen);
    $display("Status seen: ok %0d, no slot %0d, pool exceeded %0d, not found %0d.",
             status_seen[wat_pkg::ST_OK], status_seen[wat_pkg::ST_NO_SLOT],
             status_seen[wat_pkg::ST_POOL_FULL], status_seen[wat_pkg::ST_NOT_FOUND]);
    if (errors == 0 && rsp_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, rsp_due.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
